@@ hdl/lfps_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lfps_pkg
// Shared types, constants and codes for the line-follow PD steering core.
// -----------------------------------------------------------------------------
package lfps_pkg;

	localparam int MIN_FORWARD      = 20;
	localparam int CURVE_SLOWDOWN   = 30;
	localparam int SEARCH_DIR_ERROR = 200;
	localparam int GAP_FORWARD      = 30;
	localparam int SEARCH_TURN      = 40;
	localparam int STEER_REVERSED   = 0;
	localparam int MAX_PERCENT      = 100;
	localparam int ALPHA_ONE        = 65536;
	localparam int SLOPE_SCALE      = 256000;
	localparam int DIV_BITS         = 30;
	localparam int DIV_CNT_W        = $clog2(DIV_BITS);
	localparam int MUL_A_W          = 25;
	localparam int MUL_B_W          = 32;
	localparam int PROD_W           = MUL_A_W + MUL_B_W;
	localparam int ACC_W            = PROD_W + 1;
	localparam int CFG_DATA_W       = 24;
	localparam int CFG_IDX_W        = 3;

	typedef enum logic [1:0] {
		REQ_UPDATE     = 2'd0,
		REQ_ACTIVATE   = 2'd1,
		REQ_DEACTIVATE = 2'd2,
		REQ_UNKNOWN    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		DA_NONE  = 2'd0,
		DA_STEER = 2'd1,
		DA_STOP  = 2'd2
	} drive_act_t;

	typedef enum logic [1:0] {
		MODE_INACTIVE   = 2'd0,
		MODE_TRACKING   = 2'd1,
		MODE_RECOVERING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} search_dir_t;

	typedef enum logic [2:0] {
		CFG_KP       = 3'd0,
		CFG_KD       = 3'd1,
		CFG_ALPHA    = 3'd2,
		CFG_DEADBAND = 3'd3,
		CFG_MAXCORR  = 3'd4,
		CFG_CRUISE   = 3'd5,
		CFG_GRACE    = 3'd6,
		CFG_TIMEOUT  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MUL_NUM   = 2'd0,
		MUL_ALPHA = 2'd1,
		MUL_KP    = 2'd2,
		MUL_KD    = 2'd3
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIV_LOAD,
		ST_DIV,
		ST_MUL_F,
		ST_FILT,
		ST_MUL_P,
		ST_MUL_D,
		ST_SUM,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic        calibration_valid;
		logic        sample_fresh;
		logic        line_detected;
		logic [9:0]  left_strength;
		logic [9:0]  right_strength;
		logic [31:0] sample_time_ms;
	} lfps_in_t;

	typedef struct packed {
		logic [1:0]        drive_action;
		logic signed [7:0] steer_percent;
		logic [6:0]        forward_percent;
		logic              activate_ok;
		logic              is_active;
		logic              is_recovering;
	} lfps_out_t;

	typedef struct packed {
		logic     load_item;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_load;
		logic     div_step;
		logic     filt_en;
		logic     acc_load;
		logic     acc_add;
		logic     commit;
	} lfps_cmd_t;

	typedef struct packed {
		logic track;
		logic div_done;
		logic out_busy;
	} lfps_sts_t;

endpackage
`default_nettype wire

@@ hdl/lfps_div.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lfps_div
// Restoring unsigned divider, one quotient bit per cycle while step is high.
// -----------------------------------------------------------------------------
module lfps_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic                          step,
	input  wire logic [lfps_pkg::DIV_BITS-1:0] num,
	input  wire logic [31:0]                   den,
	output logic      [lfps_pkg::DIV_BITS-1:0] quo,
	output logic                               done
);
	import lfps_pkg::*;

	logic [31:0]          rem_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [31:0]          den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [32:0]          trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (step) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = cnt_q == DIV_CNT_W'(DIV_BITS - 1);
endmodule
`default_nettype wire

@@ hdl/lfps_ctrl.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lfps_ctrl
// Sequencer that steps the datapath through one item.
// -----------------------------------------------------------------------------
module lfps_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lfps_pkg::lfps_sts_t sts,
	output lfps_pkg::lfps_cmd_t      cmd
);
	import lfps_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_START;
			ST_START:    state_nxt = sts.track ? ST_DIV_LOAD : ST_COMMIT;
			ST_DIV_LOAD: state_nxt = ST_DIV;
			ST_DIV:      if (sts.div_done) state_nxt = ST_MUL_F;
			ST_MUL_F:    state_nxt = ST_FILT;
			ST_FILT:     state_nxt = ST_MUL_P;
			ST_MUL_P:    state_nxt = ST_MUL_D;
			ST_MUL_D:    state_nxt = ST_SUM;
			ST_SUM:      state_nxt = ST_COMMIT;
			ST_COMMIT:   if (!sts.out_busy) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_NUM;
		case (state_q)
			ST_IDLE:     cmd.load_item = in_valid;
			ST_START:    cmd.mul_en = 1'b1;
			ST_DIV_LOAD: cmd.div_load = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_MUL_F: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ALPHA;
			end
			ST_FILT:     cmd.filt_en = 1'b1;
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_KP;
			end
			ST_MUL_D: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_KD;
				cmd.acc_load = 1'b1;
			end
			ST_SUM:      cmd.acc_add = 1'b1;
			ST_COMMIT:   cmd.commit = !sts.out_busy;
			default:     cmd = '0;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
endmodule
`default_nettype wire

@@ hdl/lfps_dp.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lfps_dp
// Datapath: configuration, mode state, shared multiplier, divider, result.
// -----------------------------------------------------------------------------
module lfps_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [lfps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lfps_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire lfps_pkg::lfps_in_t                   in_item,
	input  wire lfps_pkg::lfps_cmd_t                  cmd,
	output lfps_pkg::lfps_sts_t                       sts,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output lfps_pkg::lfps_out_t                       out_item
);
	import lfps_pkg::*;

	// Configuration registers.
	logic signed [23:0] kp_q, kd_q;
	logic [16:0]        alpha_q;
	logic [9:0]         deadband_q;
	logic [6:0]         maxcorr_q, cruise_q;
	logic [15:0]        grace_q, timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			kd_q       <= '0;
			alpha_q    <= 17'(ALPHA_ONE);
			deadband_q <= '0;
			maxcorr_q  <= 7'(MAX_PERCENT);
			cruise_q   <= 7'd50;
			grace_q    <= 16'd100;
			timeout_q  <= 16'd1000;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KP:       kp_q       <= cfg_data;
				CFG_KD:       kd_q       <= cfg_data;
				CFG_ALPHA:    alpha_q    <= cfg_data[16:0];
				CFG_DEADBAND: deadband_q <= cfg_data[9:0];
				CFG_MAXCORR:  maxcorr_q  <= cfg_data[6:0];
				CFG_CRUISE:   cruise_q   <= cfg_data[6:0];
				CFG_GRACE:    grace_q    <= cfg_data[15:0];
				CFG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
				default:      kp_q       <= kp_q;
			endcase
		end
	end

	// Controller state.
	mode_t              mode_q, mode_n;
	logic               seen_q, seen_n;
	logic               hprior_q, hprior_n;
	logic [31:0]        lsample_q, lsample_n;
	logic [31:0]        lseen_q, lseen_n;
	logic signed [10:0] prior_q, prior_n;
	logic signed [31:0] fslope_q, fslope_n;
	logic signed [7:0]  lcorr_q, lcorr_n;
	search_dir_t        sdir_q, sdir_n;

	lfps_in_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_item;
		end
	end

	// Error with deadband.
	logic signed [10:0] err_raw, err;
	logic [9:0]         mag_raw, mag;
	logic               dup, upd_ok, line_trk, prior_eff;
	logic signed [31:0] filt_base;
	logic [31:0]        elapsed;
	logic signed [11:0] diff;

	assign err_raw = (STEER_REVERSED != 0) ?
	                 signed'({1'b0, item_q.left_strength}) -
	                 signed'({1'b0, item_q.right_strength}) :
	                 signed'({1'b0, item_q.right_strength}) -
	                 signed'({1'b0, item_q.left_strength});
	assign mag_raw = err_raw[10] ? 10'(-err_raw) : err_raw[9:0];
	assign err     = (mag_raw <= deadband_q) ? '0 : err_raw;
	assign mag     = (mag_raw <= deadband_q) ? '0 : mag_raw;

	assign dup      = seen_q && (item_q.sample_time_ms == lsample_q);
	assign upd_ok   = (req_t'(item_q.req_type) == REQ_UPDATE) && (mode_q != MODE_INACTIVE) &&
	                  item_q.calibration_valid && item_q.sample_fresh && !dup;
	assign line_trk = upd_ok && item_q.line_detected;
	assign prior_eff = hprior_q && (mode_q != MODE_RECOVERING);
	assign filt_base = (mode_q == MODE_RECOVERING) ? '0 : fslope_q;
	assign elapsed   = item_q.sample_time_ms - lsample_q;
	assign diff      = 12'(err) - 12'(prior_q);

	// Shared multiplier.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [31:0]        raw, delta, filt_q;
	logic [16:0]               alpha_eff;

	assign alpha_eff = (alpha_q > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE) : alpha_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_NUM: begin
				mul_a = MUL_A_W'(SLOPE_SCALE);
				mul_b = MUL_B_W'(diff);
			end
			MUL_ALPHA: begin
				mul_a = signed'({8'd0, alpha_eff});
				mul_b = delta;
			end
			MUL_KP: begin
				mul_a = MUL_A_W'(kp_q);
				mul_b = MUL_B_W'(err);
			end
			MUL_KD: begin
				mul_a = MUL_A_W'(kd_q);
				mul_b = filt_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Slope division.
	logic [DIV_BITS-1:0] num_mag, quo;
	logic                num_neg_q, div_done;
	logic signed [PROD_W-1:0] prod_abs;

	assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign num_mag  = prod_abs[DIV_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_neg_q <= prod_q[PROD_W-1];
		end
	end

	lfps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.div_load),
		.step   (cmd.div_step),
		.num    (num_mag),
		.den    (elapsed),
		.quo    (quo),
		.done   (div_done)
	);

	always_comb begin
		if (!prior_eff || elapsed == 32'd0) begin
			raw = '0;
		end else if (num_neg_q) begin
			raw = -signed'(32'(quo));
		end else begin
			raw = signed'(32'(quo));
		end
	end
	assign delta = raw - filt_base;

	// Filter update, division by 65536 truncated toward zero.
	logic signed [PROD_W-1:0] prod_bias;
	logic signed [PROD_W-1:0] prod_shr;

	assign prod_bias = prod_q[PROD_W-1] ? prod_q + PROD_W'(ALPHA_ONE - 1) : prod_q;
	assign prod_shr  = prod_bias >>> 16;

	always_ff @(posedge clk) begin
		if (cmd.filt_en) begin
			filt_q <= filt_base + prod_shr[31:0];
		end
	end

	// PD sum.
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			acc_q <= ACC_W'(prod_q) <<< 8;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// Round half away from zero, then clamp.
	logic [ACC_W-1:0]  acc_abs, acc_rnd;
	logic [6:0]        lim, rc;
	logic signed [7:0] corr;

	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign acc_rnd = (acc_abs + ACC_W'(24'h800000)) >> 24;
	assign lim     = (maxcorr_q > 7'(MAX_PERCENT)) ? 7'(MAX_PERCENT) : maxcorr_q;
	assign rc      = (acc_rnd > ACC_W'(lim)) ? lim : acc_rnd[6:0];
	assign corr    = acc_q[ACC_W-1] ? -signed'({1'b0, rc}) : signed'({1'b0, rc});

	// Forward speed with curve slowdown; x/1000 as (x*134218)>>27 for x<=100000.
	logic [6:0]  cruise_c;
	logic [16:0] mag_k;
	logic [34:0] slow_prod;
	logic [6:0]  slow;
	logic signed [7:0] fwd_raw;
	logic [6:0]  fwd;

	assign cruise_c  = (cruise_q == 7'd0) ? 7'd1 :
	                   (cruise_q > 7'(MAX_PERCENT)) ? 7'(MAX_PERCENT) : cruise_q;
	assign mag_k     = 17'(mag) * 17'(CURVE_SLOWDOWN);
	assign slow_prod = 35'(mag_k) * 35'd134218;
	assign slow      = slow_prod[33:27];
	assign fwd_raw   = signed'({1'b0, cruise_c}) - signed'({1'b0, slow});
	assign fwd       = (fwd_raw < signed'(8'(MIN_FORWARD))) ? 7'(MIN_FORWARD) :
	                   fwd_raw[6:0];

	// Line-loss handling.
	logic [31:0]       lost;
	logic signed [7:0] gap_steer;

	assign lost      = item_q.now_ms - lseen_q;
	assign gap_steer = (lcorr_q > signed'(8'(GAP_FORWARD))) ? 8'(GAP_FORWARD) :
	                   (lcorr_q < -signed'(8'(GAP_FORWARD))) ? -8'(GAP_FORWARD) :
	                   lcorr_q;

	// Next state and result.
	lfps_out_t res;

	always_comb begin
		mode_n    = mode_q;
		seen_n    = seen_q;
		hprior_n  = hprior_q;
		lsample_n = lsample_q;
		lseen_n   = lseen_q;
		prior_n   = prior_q;
		fslope_n  = fslope_q;
		lcorr_n   = lcorr_q;
		sdir_n    = sdir_q;
		res       = '0;
		res.drive_action = DA_NONE;
		case (req_t'(item_q.req_type))
			REQ_ACTIVATE: begin
				if (item_q.calibration_valid && item_q.sample_fresh &&
				    item_q.line_detected) begin
					{seen_n, hprior_n, lsample_n, prior_n, fslope_n, lcorr_n} = '0;
					sdir_n          = DIR_NONE;
					mode_n          = MODE_TRACKING;
					lseen_n         = item_q.now_ms;
					res.activate_ok = 1'b1;
				end
			end
			REQ_DEACTIVATE: begin
				{seen_n, hprior_n, lsample_n, lseen_n, prior_n, fslope_n, lcorr_n} = '0;
				sdir_n = DIR_NONE;
				mode_n = MODE_INACTIVE;
			end
			REQ_UPDATE: begin
				if (mode_q != MODE_INACTIVE) begin
					if (!item_q.calibration_valid || !item_q.sample_fresh) begin
						{seen_n, hprior_n, lsample_n, lseen_n, prior_n, fslope_n,
						 lcorr_n} = '0;
						sdir_n           = DIR_NONE;
						mode_n           = MODE_INACTIVE;
						res.drive_action = DA_STOP;
					end else if (!dup) begin
						seen_n    = 1'b1;
						lsample_n = item_q.sample_time_ms;
						if (item_q.line_detected) begin
							fslope_n = filt_q;
							lcorr_n  = corr;
							if (mag >= 10'(SEARCH_DIR_ERROR)) begin
								sdir_n = (err > 11'sd0) ? DIR_POS : DIR_NEG;
							end
							prior_n  = err;
							hprior_n = 1'b1;
							lseen_n  = item_q.now_ms;
							mode_n   = MODE_TRACKING;
							res.drive_action    = DA_STEER;
							res.steer_percent   = corr;
							res.forward_percent = fwd;
						end else begin
							mode_n = MODE_RECOVERING;
							if (lost <= 32'(grace_q)) begin
								res.drive_action    = DA_STEER;
								res.steer_percent   = gap_steer;
								res.forward_percent = 7'(GAP_FORWARD);
							end else if (sdir_q != DIR_NONE &&
							             lost <= 32'(timeout_q)) begin
								res.drive_action  = DA_STEER;
								res.steer_percent = (sdir_q == DIR_POS) ?
								                    8'(SEARCH_TURN) : -8'(SEARCH_TURN);
							end else begin
								{seen_n, hprior_n, lseen_n, prior_n, fslope_n,
								 lcorr_n} = '0;
								sdir_n           = DIR_NONE;
								mode_n           = MODE_INACTIVE;
								res.drive_action = DA_STOP;
							end
						end
					end
				end
			end
			default: res.drive_action = DA_NONE;
		endcase
		res.is_active     = mode_n != MODE_INACTIVE;
		res.is_recovering = mode_n == MODE_RECOVERING;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INACTIVE;
			seen_q    <= 1'b0;
			hprior_q  <= 1'b0;
			lsample_q <= '0;
			lseen_q   <= '0;
			prior_q   <= '0;
			fslope_q  <= '0;
			lcorr_q   <= '0;
			sdir_q    <= DIR_NONE;
		end else if (cmd.commit) begin
			mode_q    <= mode_n;
			seen_q    <= seen_n;
			hprior_q  <= hprior_n;
			lsample_q <= lsample_n;
			lseen_q   <= lseen_n;
			prior_q   <= prior_n;
			fslope_q  <= fslope_n;
			lcorr_q   <= lcorr_n;
			sdir_q    <= sdir_n;
		end
	end

	// Output register.
	logic      out_valid_q;
	lfps_out_t out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_item_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_item     = out_item_q;
	assign sts.track    = line_trk;
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && out_stall;
endmodule
`default_nettype wire

@@ hdl/line_follow_pd_steering_core.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// line_follow_pd_steering_core
// PD line-follow steering with a filtered derivative and line-loss recovery.
// -----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall   lfps_in_t  (request and sample)
//   out      output     out_valid / out_stall lfps_out_t (drive command)
//   cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// An update that tracks a seen line passes through the 30-step restoring
// divider for the raw slope and the multiplier states on its way to the
// output register; every other item goes from ST_START straight to ST_COMMIT.
// One item is in work at a time; a finished item waits in the output register
// while the next item is accepted, and commit waits only if that register is
// still held by out_stall. Reset is asynchronous and clears the mode state
// and configuration to their power-on values.
//
module line_follow_pd_steering_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire lfps_pkg::lfps_in_t              in_item,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output lfps_pkg::lfps_out_t                  out_item
);
	import lfps_pkg::*;

	lfps_cmd_t cmd;
	lfps_sts_t sts;

	// The sequencer owns the input handshake and steps the datapath.
	lfps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds configuration, mode state and the output register.
	lfps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// An accepted item keeps the input side busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// Only the three defined drive actions are ever produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.drive_action == DA_NONE ||
		               out_item.drive_action == DA_STEER ||
		               out_item.drive_action == DA_STOP))
		else $error("bad drive action");

	// Speed and steering are zero unless a steering command is given.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.drive_action != DA_STEER) |->
		(out_item.steer_percent == 8'sd0 && out_item.forward_percent == 7'd0))
		else $error("command fields set without steering action");

	// Recovery is a sub-mode of being active.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.is_recovering) |-> out_item.is_active)
		else $error("recovering while inactive");
endmodule
`default_nettype wire

@@ tb/sv/line_follow_pd_steering_core_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// line_follow_pd_steering_core_tb
// Self-checking testbench for the line-follow PD steering core. A scoreboard
// class predicts every drive command from the accepted requests and compares
// each delivered item with the oldest prediction. Directed requests cover the
// mode machine's corner cases, then random activate/update/deactivate episodes
// run under several register settings with random sender gaps and receiver
// stalls.
// -----------------------------------------------------------------------------
module line_follow_pd_steering_core_tb;
	import lfps_pkg::*;

	// Predicts the drive command of each request and keeps the pending ones.
	class steer_scoreboard;
		logic signed [23:0] kp, kd;
		logic [16:0] alpha;
		logic [9:0]  deadband;
		logic [6:0]  max_corr, cruise;
		logic [15:0] grace_ms, timeout_ms;

		mode_t       mode;
		bit          seen_sample, have_prior;
		bit   [31:0] last_sample_ms, last_seen_ms;
		int          prior_err, filt_slope, last_corr, search_dir;

		lfps_out_t   pending[$];
		int          mismatches;
		int          delivered;

		function new();
			kp = 0; kd = 0; alpha = ALPHA_ONE; deadband = 0;
			max_corr = 100; cruise = 50; grace_ms = 100; timeout_ms = 1000;
			mismatches = 0; delivered = 0;
			clear_mode_state();
		endfunction

		function void clear_mode_state();
			mode = MODE_INACTIVE; seen_sample = 0; have_prior = 0;
			last_sample_ms = 0; last_seen_ms = 0; prior_err = 0;
			filt_slope = 0; last_corr = 0; search_dir = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_KP:       kp = val;
				CFG_KD:       kd = val;
				CFG_ALPHA:    alpha = val[16:0];
				CFG_DEADBAND: deadband = val[9:0];
				CFG_MAXCORR:  max_corr = val[6:0];
				CFG_CRUISE:   cruise = val[6:0];
				CFG_GRACE:    grace_ms = val[15:0];
				CFG_TIMEOUT:  timeout_ms = val[15:0];
				default:      ;
			endcase
		endfunction

		function longint clamp(longint x, longint lo, longint hi);
			return (x < lo) ? lo : ((x > hi) ? hi : x);
		endfunction

		// Accepted request: compute its drive command and queue it.
		function void note_request(lfps_in_t it);
			lfps_out_t  r;
			drive_act_t act;
			longint     steer, fwd, err, mag, raw, a, sum, rounded, lim, cr, f;
			bit  [31:0] el, lost;
			bit         ok;
			act = DA_NONE; steer = 0; fwd = 0; ok = 0;
			if (it.req_type == REQ_ACTIVATE) begin
				if (it.calibration_valid && it.sample_fresh && it.line_detected) begin
					clear_mode_state();
					mode = MODE_TRACKING;
					last_seen_ms = it.now_ms;
					ok = 1;
				end
			end else if (it.req_type == REQ_DEACTIVATE) begin
				clear_mode_state();
			end else if (it.req_type == REQ_UPDATE && mode != MODE_INACTIVE) begin
				if (!it.calibration_valid || !it.sample_fresh) begin
					clear_mode_state();
					act = DA_STOP;
				end else if (!(seen_sample && it.sample_time_ms == last_sample_ms)) begin
					seen_sample = 1;
					if (it.line_detected) begin
						err = longint'(it.right_strength) - longint'(it.left_strength);
						if (STEER_REVERSED != 0)
							err = -err;
						mag = (err < 0) ? -err : err;
						if (mag <= longint'(deadband)) begin
							err = 0;
							mag = 0;
						end
						// Coming back from recovery restarts the derivative.
						if (mode == MODE_RECOVERING) begin
							have_prior = 0;
							filt_slope = 0;
						end
						raw = 0;
						if (have_prior) begin
							el = it.sample_time_ms - last_sample_ms;
							if (el != 0)
								raw = ((err - prior_err) * SLOPE_SCALE) / longint'(el);
						end
						a = (alpha > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha);
						filt_slope = int'(longint'(filt_slope)
							+ (a * (raw - filt_slope)) / ALPHA_ONE);
						sum = longint'(kp) * err * 256 + longint'(kd) * filt_slope;
						// Round half away from zero out of 24 fraction bits.
						if (sum >= 0)
							rounded = (sum + 64'h80_0000) / 64'h100_0000;
						else
							rounded = -((-sum + 64'h80_0000) / 64'h100_0000);
						lim = (max_corr > MAX_PERCENT) ? MAX_PERCENT : longint'(max_corr);
						last_corr = int'(clamp(rounded, -lim, lim));
						cr = clamp(cruise, 1, MAX_PERCENT);
						f = cr - (mag * CURVE_SLOWDOWN) / 1000;
						if (f < MIN_FORWARD)
							f = MIN_FORWARD;
						else if (f > cr)
							f = cr;
						steer = last_corr;
						fwd = f;
						if (mag >= SEARCH_DIR_ERROR)
							search_dir = (err > 0) ? 1 : -1;
						prior_err = int'(err);
						have_prior = 1;
						last_seen_ms = it.now_ms;
						mode = MODE_TRACKING;
						act = DA_STEER;
					end else begin
						lost = it.now_ms - last_seen_ms;
						mode = MODE_RECOVERING;
						if (lost <= grace_ms) begin
							steer = clamp(last_corr, -GAP_FORWARD, GAP_FORWARD);
							fwd = GAP_FORWARD;
							act = DA_STEER;
						end else if (search_dir != 0 && lost <= timeout_ms) begin
							steer = search_dir * SEARCH_TURN;
							fwd = 0;
							act = DA_STEER;
						end else begin
							clear_mode_state();
							act = DA_STOP;
						end
					end
					last_sample_ms = it.sample_time_ms;
				end
			end
			if (act != DA_STEER) begin
				steer = 0;
				fwd = 0;
			end
			r.drive_action    = act;
			r.steer_percent   = steer[7:0];
			r.forward_percent = fwd[6:0];
			r.activate_ok     = ok;
			r.is_active       = (mode != MODE_INACTIVE);
			r.is_recovering   = (mode == MODE_RECOVERING);
			pending.push_back(r);
		endfunction

		// Delivered drive command: compare with the oldest prediction.
		function void check_command(lfps_out_t got);
			lfps_out_t exp_cmd;
			delivered++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected command %0d: %h", delivered, got);
				return;
			end
			exp_cmd = pending.pop_front();
			if (got.drive_action !== exp_cmd.drive_action
			    || got.steer_percent !== exp_cmd.steer_percent
			    || got.forward_percent !== exp_cmd.forward_percent
			    || got.activate_ok !== exp_cmd.activate_ok
			    || got.is_active !== exp_cmd.is_active
			    || got.is_recovering !== exp_cmd.is_recovering) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: command %0d: expected act=%0d steer=%0d fwd=%0d ok=%0b",
						" act=%0b rec=%0b, got act=%0d steer=%0d fwd=%0d ok=%0b",
						" act=%0b rec=%0b"}, delivered,
						exp_cmd.drive_action, exp_cmd.steer_percent,
						exp_cmd.forward_percent, exp_cmd.activate_ok,
						exp_cmd.is_active, exp_cmd.is_recovering,
						got.drive_action, got.steer_percent, got.forward_percent,
						got.activate_ok, got.is_active, got.is_recovering);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	lfps_in_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	lfps_out_t             out_item;

	steer_scoreboard sb;

	// Sender burst bookkeeping and the clock model of the robot.
	int          burst_left;
	int          sent_count;
	bit   [31:0] t_now;
	bit   [31:0] t_samp;

	// Receiver: stall_style picks the stall pattern and is redrawn periodically from
	// rx_cycle; hold_cycles forces a long hold-off so the core fills up and stalls its input.
	int          hold_cycles;
	int          stall_style;
	int          rx_cycle;

	line_follow_pd_steering_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver stall generation, changed on the falling edge only.
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			stall_style <= $urandom_range(0, 3);
		if (hold_cycles > 0) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= (rx_cycle % 5 < 2);
			endcase
		end
	end

	// Every item delivered at a rising edge goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_command(out_item);
	end

	// Offers one item, holding it until the core takes it. Between bursts the
	// valid may drop for a random number of cycles.
	task automatic push_item(input lfps_in_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_item  = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(it);
		burst_left--;
		sent_count++;
		@(negedge clk);
	endtask

	function automatic lfps_in_t make_req(req_t req, bit calib, bit fresh, bit line,
	                                      int left, int right);
		lfps_in_t it;
		it.req_type          = req;
		it.now_ms            = t_now;
		it.calibration_valid = calib;
		it.sample_fresh      = fresh;
		it.line_detected     = line;
		it.left_strength     = left[9:0];
		it.right_strength    = right[9:0];
		it.sample_time_ms    = t_samp;
		return it;
	endfunction

	// Waits until every command has been delivered, with the input valid held low.
	task automatic drain();
		in_valid   = 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic load_setting(input logic [CFG_DATA_W-1:0] p, d, a, db, mc, cr, gr, to);
		drain();
		write_reg(CFG_KP, p);
		write_reg(CFG_KD, d);
		write_reg(CFG_ALPHA, a);
		write_reg(CFG_DEADBAND, db);
		write_reg(CFG_MAXCORR, mc);
		write_reg(CFG_CRUISE, cr);
		write_reg(CFG_GRACE, gr);
		write_reg(CFG_TIMEOUT, to);
	endtask

	function automatic int strength();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1000;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	// One activation episode: mostly well-formed updates with random content,
	// with line-loss stretches, duplicates and the odd bad sample.
	task automatic run_episode();
		int lost_run;
		int sel;
		lost_run = 0;
		if ($urandom_range(0, 7) == 0)
			t_now = $urandom;
		else
			t_now += $urandom_range(1, 50);
		t_samp = t_now - $urandom_range(0, 3);
		push_item(make_req(REQ_ACTIVATE, 1, 1, 1, strength(), strength()));
		repeat ($urandom_range(4, 30)) begin
			sel = $urandom_range(0, 99);
			if (sel >= 4)
				t_samp += $urandom_range(1, 25);
			if (lost_run == 0 && $urandom_range(0, 9) == 0)
				lost_run = $urandom_range(1, 6);
			if (lost_run > 0) begin
				lost_run--;
				t_now += ($urandom_range(0, 2) == 0) ? $urandom_range(100, 1500)
					: $urandom_range(1, 60);
			end else begin
				t_now += $urandom_range(1, 25);
			end
			push_item(make_req(REQ_UPDATE, sel != 4, sel != 5, lost_run == 0 && sel != 6,
				strength(), strength()));
		end
		if ($urandom_range(0, 1) == 0)
			push_item(make_req(REQ_DEACTIVATE, 1'($urandom), 1'($urandom), 1'($urandom),
				strength(), strength()));
	endtask

	// Fully random requests, including the unknown code.
	task automatic push_noise();
		lfps_in_t it;
		it.req_type          = 2'($urandom_range(0, 3));
		it.now_ms            = $urandom;
		it.calibration_valid = 1'($urandom);
		it.sample_fresh      = 1'($urandom);
		it.line_detected     = 1'($urandom);
		it.left_strength     = 10'(strength());
		it.right_strength    = 10'(strength());
		it.sample_time_ms    = $urandom;
		push_item(it);
	endtask

	task automatic run_random(input int count);
		int target;
		target = sent_count + count;
		while (sent_count < target) begin
			if ($urandom_range(0, 99) < 85)
				run_episode();
			else
				push_noise();
		end
	endtask

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_item     = '0;
		out_stall   = 1'b0;
		hold_cycles = 0;
		stall_style = 0;
		rx_cycle    = 0;
		burst_left  = 0;
		sent_count  = 0;
		t_now       = 1000;
		t_samp      = 1000;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, under the power-on settings first.
		push_item(make_req(REQ_UNKNOWN, 1, 1, 1, 500, 500));
		push_item(make_req(REQ_UPDATE, 1, 1, 1, 0, 1000));
		push_item(make_req(REQ_ACTIVATE, 0, 1, 1, 0, 0));
		push_item(make_req(REQ_ACTIVATE, 1, 0, 1, 0, 0));
		push_item(make_req(REQ_ACTIVATE, 1, 1, 0, 0, 0));
		load_setting(24'h01_0000, 24'h00_8000, 24'h1_0000, 0, 100, 50, 100, 1000);
		push_item(make_req(REQ_ACTIVATE, 1, 1, 1, 0, 0));
		t_samp += 10; t_now += 10;
		push_item(make_req(REQ_UPDATE, 1, 1, 1, 0, 1000));
		push_item(make_req(REQ_UPDATE, 1, 1, 1, 0, 1000));  // same sample again
		t_samp += 5; t_now += 5;
		push_item(make_req(REQ_UPDATE, 1, 1, 1, 1000, 0));
		t_samp += 5; t_now += 50;
		push_item(make_req(REQ_UPDATE, 1, 1, 0, 0, 0));      // inside the grace time
		t_samp += 5; t_now += 300;
		push_item(make_req(REQ_UPDATE, 1, 1, 0, 0, 0));      // search turn
		t_samp += 5; t_now += 5;
		push_item(make_req(REQ_UPDATE, 1, 1, 1, 400, 700));  // back on the line
		t_samp += 5; t_now += 5;
		push_item(make_req(REQ_UPDATE, 1, 1, 0, 0, 0));
		t_samp += 5; t_now += 2000;
		push_item(make_req(REQ_UPDATE, 1, 1, 0, 0, 0));      // search timed out
		push_item(make_req(REQ_ACTIVATE, 1, 1, 1, 0, 0));
		t_samp += 5;
		push_item(make_req(REQ_UPDATE, 1, 0, 1, 0, 0));      // stale sample stops
		push_item(make_req(REQ_ACTIVATE, 1, 1, 1, 0, 0));
		t_samp += 5;
		push_item(make_req(REQ_UPDATE, 0, 1, 1, 0, 0));      // lost calibration
		push_item(make_req(REQ_ACTIVATE, 1, 1, 1, 0, 0));
		t_samp += 5;
		push_item(make_req(REQ_UPDATE, 1, 1, 1, 1000, 1000));
		push_item(make_req(REQ_DEACTIVATE, 1, 1, 1, 0, 0));

		run_random(140);

		// Receiver holds off for a long stretch while the sender keeps going.
		hold_cycles = 400;
		burst_left  = 40;
		run_random(40);

		// Extreme settings, Kp at its positive top and Kd at its negative bottom.
		load_setting(24'h7F_FFFF, 24'h80_0000, 1, 1000, 0, 100, 0, 1);
		run_random(130);
		// Out-of-range alpha, correction limit and cruise, widest times.
		load_setting(24'h80_0000, 24'h7F_FFFF, 24'h1_FFFF, 50, 127, 127, 65535, 65535);
		run_random(130);
		load_setting(24'h00_4000, 24'h7F_0000, 0, 10, 30, 0, 20, 65535);
		run_random(130);
		// Random settings for the rest.
		repeat (3) begin
			load_setting(24'($urandom_range(0, 24'hFF_FFFF)),
				24'($urandom_range(0, 24'hFF_FFFF)),
				24'($urandom_range(1, 65536)), 24'($urandom_range(0, 300)),
				24'($urandom_range(0, 100)), 24'($urandom_range(1, 100)),
				24'($urandom_range(0, 400)), 24'($urandom_range(1, 2000)));
			run_random(80);
		end

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ line_follow_pd_steering_core.f @@
hdl/lfps_pkg.sv
hdl/lfps_div.sv
hdl/lfps_ctrl.sv
hdl/lfps_dp.sv
hdl/line_follow_pd_steering_core.sv
tb/sv/line_follow_pd_steering_core_tb.sv
